### rtl/pbba_pkg.sv
// ----------------------------------------------------------------------------
// pbba_pkg
// Shared types, constants and helpers of the power-of-two bucket allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pbba_pkg;

    // field widths
    localparam int REQ_W     = 17;
    localparam int ADDR_W    = 16;
    localparam int CLS_W     = 4;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int BKT_W     = 5;

    // arithmetic widths
    localparam int SZ_W  = 18;
    localparam int LEN_W = 19;
    localparam int AMT_W = 20;

    // allocator constants
    localparam int ADDR_CEIL  = 65528;
    localparam int SAT_BUCKET = 14;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_ALLOC   = 2'd0;
    localparam logic [ST_W-1:0] ST_OOM     = 2'd1;
    localparam logic [ST_W-1:0] ST_FREED   = 2'd2;
    localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE      = 1'd1;

    typedef struct packed {
        logic              kind;
        logic [REQ_W-1:0]  request_bytes;
        logic [ADDR_W-1:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_address;
        logic [CLS_W-1:0]  size_class;
        logic [ST_W-1:0]   status;
    } t_out_item;

    // per 8-byte slot tag
    typedef struct packed {
        logic              in_use;
        logic [BKT_W-1:0]  bucket;
        logic [ADDR_W-1:0] next;
    } t_tag;

    // controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic take;
        logic size_init;
        logic size_step;
        logic tag_rd_head;
        logic pop;
        logic sz_load;
        logic walk_rd;
        logic walk_next;
        logic page_open;
        logic page_hit;
        logic carve;
        logic tag_rd_free;
        logic free_do;
        logic res_oom0;
        logic res_oom_b;
        logic res_ignore;
        logic push;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic in_kind;
        logic size_more;
        logic bkt_oob;
        logic head_hit;
        logic walk_empty;
        logic walk_fit;
        logic page_ok;
        logic free_ok;
        logic tag_in_use;
        logic slot_free;
    } t_sts;

    // smallest p with (8 << p) >= pb
    function automatic logic [BKT_W-1:0] page_bucket(input logic [CFG_W-1:0] pb);
        logic [BKT_W-1:0] cnt;
        cnt = '0;
        for (int k = 0; k < SAT_BUCKET; k++) begin
            if ((18'd8 << k) < {1'b0, pb}) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

endpackage

`default_nettype wire

### rtl/pbba_ctrl.sv
// ----------------------------------------------------------------------------
// pbba_ctrl
// Sequencer of the allocator: clearing pass, bucket sizing, list pop,
// page walk, page open, carve and free.
// ----------------------------------------------------------------------------
`default_nettype none

module pbba_ctrl import pbba_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output logic      o_in_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INIT, S_SIZE, S_HEAD, S_POP, S_WALK, S_CMP,
        S_OPEN, S_CARVE, S_FCHK, S_FDEC, S_OUT
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = (i_sts.in_kind == KIND_FREE) ? S_FCHK : S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.size_init = 1'b1;
                n_state = S_SIZE;
            end
            S_SIZE: begin
                if (i_sts.size_more) begin
                    o_cmd.size_step = 1'b1;
                end else if (i_sts.bkt_oob) begin
                    o_cmd.res_oom0 = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_sts.head_hit) begin
                    o_cmd.tag_rd_head = 1'b1;
                    n_state = S_POP;
                end else begin
                    o_cmd.sz_load = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_state = S_OUT;
            end
            S_WALK: begin
                if (i_sts.walk_empty) begin
                    n_state = S_OPEN;
                end else begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.walk_fit) begin
                    o_cmd.page_hit = 1'b1;
                    n_state = S_CARVE;
                end else begin
                    o_cmd.walk_next = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_OPEN: begin
                if (i_sts.page_ok) begin
                    o_cmd.page_open = 1'b1;
                    n_state = S_CARVE;
                end else begin
                    o_cmd.res_oom_b = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_CARVE: begin
                o_cmd.carve = 1'b1;
                n_state = S_OUT;
            end
            S_FCHK: begin
                if (i_sts.free_ok) begin
                    o_cmd.tag_rd_free = 1'b1;
                    n_state = S_FDEC;
                end else begin
                    o_cmd.res_ignore = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_FDEC: begin
                if (i_sts.tag_in_use) begin
                    o_cmd.free_do = 1'b1;
                end else begin
                    o_cmd.res_ignore = 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.slot_free) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

### rtl/pbba_dp.sv
// ----------------------------------------------------------------------------
// pbba_dp
// Allocator datapath: configuration, bucket heads, tag memory, page
// descriptor memories, size arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbba_dp import pbba_pkg::*; #(
    parameter int ARENA_BYTES = 65536,
    parameter int NUM_BUCKETS = 16,
    parameter int MAX_PAGES   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_in_item             i_in,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_out_stall,
    input  wire t_cmd                 i_cmd,
    output t_sts                      o_sts,
    output logic                      o_out_valid,
    output t_out_item                 o_out
);

    localparam int TAG_DEPTH   = ARENA_BYTES / 8;
    localparam int TAG_MEM     = (TAG_DEPTH < 8192) ? TAG_DEPTH : 8192;
    localparam int TAG_AW      = $clog2(TAG_MEM);
    localparam int ARENA_LIMIT = (ARENA_BYTES < ADDR_CEIL) ? ARENA_BYTES : ADDR_CEIL;
    localparam int BK_AW       = $clog2(NUM_BUCKETS);
    localparam int PG_AW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PC_W        = $clog2(MAX_PAGES + 1);

    // configuration and control state
    logic [CFG_W-1:0]  r_init_page, r_page;
    logic [PC_W-1:0]   r_pc;
    logic [REQ_W-1:0]  r_top;
    logic [ADDR_W-1:0] r_heads [NUM_BUCKETS];
    logic [TAG_AW-1:0] r_clr;
    logic              r_out_valid;

    // working registers
    logic              r_kind;
    logic [REQ_W-1:0]  r_req;
    logic [ADDR_W-1:0] r_addr;
    logic [AMT_W-1:0]  r_amt;
    logic [CFG_W-1:0]  r_extra;
    logic [BKT_W-1:0]  r_b, r_pbk;
    logic [SZ_W-1:0]   r_sz;
    logic [PC_W-1:0]   r_walk;
    logic [PG_AW-1:0]  r_found;
    logic [ADDR_W-1:0] r_hdr;
    logic [REQ_W-1:0]  r_rem;
    t_out_item         r_res, r_out;

    // memories
    t_tag              r_tag_mem [TAG_MEM];
    t_tag              r_tag_q;
    logic [ADDR_W-1:0] r_cur_mem [MAX_PAGES];
    logic [REQ_W-1:0]  r_rem_mem [MAX_PAGES];
    logic [ADDR_W-1:0] r_cur_q;
    logic [REQ_W-1:0]  r_rem_q;

    // combinational helpers
    logic              small_req;
    logic [BK_AW-1:0]  hd_idx;
    logic [ADDR_W-1:0] head;
    logic [12:0]       head_t13, free_t13;
    logic [TAG_AW-1:0] head_tidx, free_tidx, carve_tidx, tag_rd_addr, tag_wr_addr;
    logic              tag_we;
    t_tag              tag_wr_data;
    logic [SZ_W-1:0]   sz_base, sz_next;
    logic [PC_W-1:0]   walk_m1;
    logic [PG_AW-1:0]  walk_addr, pg_wr_addr;
    logic [CFG_W-1:0]  cur_len;
    logic [LEN_W-1:0]  need, len_max, len;
    logic              pg_we;
    logic [ADDR_W-1:0] pg_wr_cur;
    logic [REQ_W-1:0]  pg_wr_rem;
    logic              slot_free;

    // bucket head lookup, shared by allocate and free
    assign hd_idx = (r_kind == KIND_FREE) ? r_tag_q.bucket[BK_AW-1:0] : r_b[BK_AW-1:0];
    assign head   = r_heads[hd_idx];

    // tag indexes
    assign head_t13   = head[15:3] - 13'd1;
    assign free_t13   = r_addr[15:3] - 13'd1;
    assign head_tidx  = head_t13[TAG_AW-1:0];
    assign free_tidx  = free_t13[TAG_AW-1:0];
    assign carve_tidx = r_hdr[TAG_AW+2:3];
    assign tag_rd_addr = i_cmd.tag_rd_free ? free_tidx : head_tidx;

    // small or large sizing rule
    assign small_req = (r_page >= 17'd8) && (r_req <= r_page - 17'd8);

    // block size, saturated where no page could ever hold it
    assign sz_base = (18'd8 << r_b) + ((r_b >= r_pbk) ? {1'b0, r_page} : 18'd0);
    assign sz_next = (r_b >= BKT_W'(SAT_BUCKET)) ? 18'h20000
                                                 : ((sz_base + 18'd7) & ~18'd7);

    // page walk address, newest first
    assign walk_m1   = r_walk - 1'b1;
    assign walk_addr = walk_m1[PG_AW-1:0];

    // new page length
    assign cur_len = (r_pc == '0) ? r_init_page : r_page;
    assign need    = {1'b0, r_sz} + 19'd16;
    assign len_max = ({2'b0, cur_len} > need) ? {2'b0, cur_len} : need;
    assign len     = (len_max + 19'd7) & ~19'd7;

    assign slot_free = !r_out_valid || !i_out_stall;

    // status to the controller
    always_comb begin
        o_sts.clear_last = (r_clr == TAG_AW'(TAG_MEM - 1));
        o_sts.in_kind    = i_in.kind;
        o_sts.size_more  = (r_b < BKT_W'(NUM_BUCKETS))
                        && ({3'b0, r_req} + 20'd8 > r_amt + {3'b0, r_extra});
        o_sts.bkt_oob    = (r_b >= BKT_W'(NUM_BUCKETS));
        o_sts.head_hit   = (head != '0);
        o_sts.walk_empty = (r_walk == '0);
        o_sts.walk_fit   = ({1'b0, r_rem_q} >= r_sz);
        o_sts.page_ok    = (r_pc < PC_W'(MAX_PAGES))
                        && ({3'b0, r_top} + {1'b0, len} <= AMT_W'(ARENA_LIMIT));
        o_sts.free_ok    = (r_addr[15:3] != 13'd0) && (r_addr[2:0] == 3'd0)
                        && (32'(free_t13) < TAG_DEPTH);
        o_sts.tag_in_use = r_tag_q.in_use;
        o_sts.slot_free  = slot_free;
    end

    // tag write port select
    always_comb begin
        tag_we      = 1'b1;
        tag_wr_addr = head_tidx;
        tag_wr_data = '{in_use: 1'b1, bucket: r_b, next: '0};
        if (i_cmd.clr_step) begin
            tag_wr_addr = r_clr;
            tag_wr_data = '0;
        end else if (i_cmd.carve) begin
            tag_wr_addr = carve_tidx;
        end else if (i_cmd.free_do) begin
            tag_wr_addr = free_tidx;
            tag_wr_data = '{in_use: 1'b0, bucket: r_tag_q.bucket, next: head};
        end else if (!i_cmd.pop) begin
            tag_we = 1'b0;
        end
    end

    // tag memory
    always_ff @(posedge i_clk) begin
        if (tag_we) r_tag_mem[tag_wr_addr] <= tag_wr_data;
        if (i_cmd.tag_rd_head || i_cmd.tag_rd_free) r_tag_q <= r_tag_mem[tag_rd_addr];
    end

    // page descriptor write port select
    assign pg_we      = i_cmd.page_open || i_cmd.carve;
    assign pg_wr_addr = i_cmd.carve ? r_found : r_pc[PG_AW-1:0];
    assign pg_wr_cur  = i_cmd.carve ? (r_hdr + r_sz[ADDR_W-1:0]) : r_top[ADDR_W-1:0];
    assign pg_wr_rem  = i_cmd.carve ? (r_rem - r_sz[REQ_W-1:0]) : len[REQ_W-1:0];

    // page descriptor memories
    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            r_cur_mem[pg_wr_addr] <= pg_wr_cur;
            r_rem_mem[pg_wr_addr] <= pg_wr_rem;
        end
        if (i_cmd.walk_rd) begin
            r_cur_q <= r_cur_mem[walk_addr];
            r_rem_q <= r_rem_mem[walk_addr];
        end
    end

    // configuration, arena state, list heads and result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_page <= 17'd4096;
            r_page      <= 17'd4096;
            r_pc        <= '0;
            r_top       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++) r_heads[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_INIT_PAGE: r_init_page <= i_cfg_wdata;
                    CFG_PAGE:      r_page      <= i_cfg_wdata;
                    default:       ;
                endcase
            end
            if (i_cmd.clr_step) r_clr <= r_clr + 1'b1;
            if (i_cmd.page_open) begin
                r_top <= r_top + len[REQ_W-1:0];
                r_pc  <= r_pc + 1'b1;
            end
            if (i_cmd.pop)     r_heads[hd_idx] <= r_tag_q.next;
            if (i_cmd.free_do) r_heads[hd_idx] <= r_addr;
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pbk <= page_bucket(r_page);
        if (i_cmd.take) begin
            r_kind <= i_in.kind;
            r_req  <= i_in.request_bytes;
            r_addr <= i_in.block_address;
        end
        if (i_cmd.size_init) begin
            r_amt   <= small_req ? 20'd8 : {3'b0, r_page};
            r_b     <= small_req ? '0 : r_pbk;
            r_extra <= small_req ? '0 : r_page;
        end
        if (i_cmd.size_step) begin
            r_amt <= r_amt << 1;
            r_b   <= r_b + 1'b1;
        end
        if (i_cmd.sz_load) begin
            r_sz   <= sz_next;
            r_walk <= r_pc;
        end
        if (i_cmd.walk_next) r_walk <= walk_m1;
        if (i_cmd.page_hit) begin
            r_found <= walk_addr;
            r_hdr   <= r_cur_q;
            r_rem   <= r_rem_q;
        end
        if (i_cmd.page_open) begin
            r_found <= r_pc[PG_AW-1:0];
            r_hdr   <= r_top[ADDR_W-1:0];
            r_rem   <= len[REQ_W-1:0];
        end
        // result of the current transaction
        if (i_cmd.pop)        r_res <= '{head, r_b[CLS_W-1:0], ST_ALLOC};
        if (i_cmd.carve)      r_res <= '{r_hdr + 16'd8, r_b[CLS_W-1:0], ST_ALLOC};
        if (i_cmd.free_do)    r_res <= '{'0, r_tag_q.bucket[CLS_W-1:0], ST_FREED};
        if (i_cmd.res_oom0)   r_res <= '{'0, '0, ST_OOM};
        if (i_cmd.res_oom_b)  r_res <= '{'0, r_b[CLS_W-1:0], ST_OOM};
        if (i_cmd.res_ignore) r_res <= '{'0, '0, ST_IGNORED};
        if (i_cmd.push)       r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

### rtl/power_of_two_bucket_allocator.sv
// ----------------------------------------------------------------------------
// power_of_two_bucket_allocator
// Segregated free-list allocator with power-of-two size classes over a
// byte arena, one allocate or free transaction at a time.
// ----------------------------------------------------------------------------
// After reset the block sweeps its tag memory clear, min(ARENA_BYTES/8, 8192)
// entries (8192 by default), and stalls its input until done; configuration
// writes are taken at any time while idle. One transaction is worked at a
// time. A free reads the slot tag unless the address is rejected before the
// tag read. An allocate first runs a size search of up to NUM_BUCKETS bucket
// steps; a bucket past the last one ends it as out of memory. Otherwise it is
// served from its bucket list, carved from an open page, or given a new page.
// The page descriptor memory is walked one page at a time, newest first, and
// a new page is opened only when no open page fits. The result sits in an
// output register, so the next transaction is accepted while a result waits
// to be taken; that transaction then waits in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module power_of_two_bucket_allocator import pbba_pkg::*; #(
    parameter int ARENA_BYTES = 65536,
    parameter int NUM_BUCKETS = 16,
    parameter int MAX_PAGES   = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    pbba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath and storage
    pbba_dp #(
        .ARENA_BYTES (ARENA_BYTES),
        .NUM_BUCKETS (NUM_BUCKETS),
        .MAX_PAGES   (MAX_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

### rtl/pbba_chk.sv
// ----------------------------------------------------------------------------
// pbba_chk
// Port-level checks of the allocator result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbba_chk import pbba_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out
);

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    // a grant is a non-null, 8-byte aligned user address
    a_grant_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_ALLOC)
        |-> (o_out.granted_address != '0) && (o_out.granted_address[2:0] == 3'd0))
        else $error("bad granted address");

    // only a grant carries an address
    a_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_ALLOC) |-> (o_out.granted_address == '0))
        else $error("address on a non-grant result");

    // an ignored free reports no class
    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_IGNORED) |-> (o_out.size_class == '0))
        else $error("class on an ignored free");

endmodule

bind power_of_two_bucket_allocator pbba_chk u_pbba_chk (.*);

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the power-of-two bucket allocator. Allocate and
// free transactions are checked against a behavioral allocator model kept in
// the bench: directed corner cases first, then random traffic under several
// page size settings with random input gaps, output stalls and one long
// output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import pbba_pkg::*;

    localparam int TAG_SLOTS    = 8192;
    localparam int BUCKETS      = 16;
    localparam int PAGES        = 16;
    localparam int WATCHDOG_MAX = 50000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_INIT_PAGE;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    power_of_two_bucket_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // allocator model state
    longint          first_page_len = 4096;
    longint          page_len = 4096;
    bit [15:0]       list_head [BUCKETS];
    bit              slot_used [TAG_SLOTS];
    bit [4:0]        slot_bucket [TAG_SLOTS];
    bit [15:0]       slot_next [TAG_SLOTS];
    longint          page_next [PAGES];
    longint          page_left [PAGES];
    int              pages_open = 0;
    longint          heap_top = 0;

    t_out_item       expected_q [$];
    logic [15:0]     live_blocks [$];
    logic [15:0]     freed_blocks [$];

    int              mismatches = 0;
    int              n_granted = 0;
    int              n_oom = 0;
    int              n_freed = 0;
    int              n_ignored = 0;
    int              idle_cycles = 0;
    int              burst_left = 0;
    bit              hold_req = 1'b0;

    function automatic longint round_up8(input longint v);
        return (v + 7) & ~64'd7;
    endfunction

    // allocate: bucket search, list pop, first-fit carve or new page
    function automatic t_out_item predict_alloc(input longint req);
        t_out_item r;
        longint    pb, amt, extra, sz, cur, plen, hdr, a;
        int        pbk, b, idx, found;
        r = '0;
        r.status = ST_ALLOC;
        pb = page_len;
        pbk = 0;
        a = 8;
        while (pb > a) begin
            a = a << 1;
            pbk++;
        end
        if (pb >= 8 && req <= pb - 8) begin
            amt = 8; b = 0; extra = 0;
        end else begin
            amt = pb; b = pbk; extra = pb;
        end
        while (b < BUCKETS && req + 8 > amt + extra) begin
            amt = amt << 1;
            b++;
        end
        if (b >= BUCKETS) begin
            r.status = ST_OOM;
            return r;
        end
        // reuse a freed block of this class
        if (list_head[b] >= 8) begin
            idx = (list_head[b] - 8) >> 3;
            r.granted_address = list_head[b];
            r.size_class = CLS_W'(b);
            list_head[b] = slot_next[idx];
            slot_used[idx] = 1'b1;
            slot_bucket[idx] = 5'(b);
            slot_next[idx] = '0;
            return r;
        end
        sz = round_up8((64'd8 << b) + ((b >= pbk) ? pb : 0));
        found = -1;
        for (int i = pages_open - 1; i >= 0 && found < 0; i--) begin
            if (page_left[i] >= sz) found = i;
        end
        if (found < 0) begin
            cur = (pages_open == 0) ? first_page_len : pb;
            plen = round_up8((cur > sz + 16) ? cur : sz + 16);
            if (pages_open >= PAGES || heap_top + plen > ADDR_CEIL) begin
                r.size_class = CLS_W'(b);
                r.status = ST_OOM;
                return r;
            end
            found = pages_open;
            page_next[found] = heap_top;
            page_left[found] = plen;
            heap_top += plen;
            pages_open++;
        end
        hdr = page_next[found];
        idx = int'(hdr >> 3);
        page_next[found] = hdr + sz;
        page_left[found] -= sz;
        slot_used[idx] = 1'b1;
        slot_bucket[idx] = 5'(b);
        slot_next[idx] = '0;
        r.granted_address = 16'(hdr + 8);
        r.size_class = CLS_W'(b);
        return r;
    endfunction

    // free: push on its class list only when tagged in use
    function automatic t_out_item predict_free(input logic [15:0] addr);
        t_out_item r;
        int        idx;
        int        b;
        r = '0;
        r.status = ST_IGNORED;
        if (addr < 8 || addr[2:0] != 3'd0) return r;
        idx = (addr - 8) >> 3;
        if (!slot_used[idx]) return r;
        b = slot_bucket[idx];
        slot_used[idx] = 1'b0;
        slot_next[idx] = list_head[b];
        list_head[b] = addr;
        r.size_class = CLS_W'(b);
        r.status = ST_FREED;
        return r;
    endfunction

    // send one transaction, predict on acceptance, then maybe pause
    task automatic send_request(input logic kind, input longint req, input logic [15:0] addr);
        t_in_item  it;
        t_out_item r;
        it.kind = kind;
        it.request_bytes = req[REQ_W-1:0];
        it.block_address = addr;
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (kind == KIND_ALLOC) begin
            r = predict_alloc(it.request_bytes);
            if (r.status == ST_ALLOC) live_blocks.push_back(r.granted_address);
        end else begin
            r = predict_free(addr);
            if (r.status == ST_FREED) freed_blocks.push_back(addr);
        end
        expected_q.push_back(r);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 8);
        end
    endtask

    task automatic alloc_req(input longint req);
        send_request(KIND_ALLOC, req, '0);
    endtask

    task automatic free_req(input logic [15:0] addr);
        send_request(KIND_FREE, '0, addr);
    endtask

    // drain all results, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_INIT_PAGE) first_page_len = val;
        else page_len = val;
    endtask

    // one random transaction: mostly alloc/free of live blocks, some noise
    task automatic random_request(input longint max_req);
        int    pick;
        int    k;
        logic [15:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            if ($urandom_range(0, 9) == 0) alloc_req($urandom_range(0, 65536));
            else if ($urandom_range(0, 3) == 0) alloc_req($urandom_range(0, max_req));
            else alloc_req($urandom_range(0, 120));
        end else if (pick < 85 && live_blocks.size() != 0) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            free_req(a);
        end else if (pick < 92 && freed_blocks.size() != 0) begin
            free_req(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
        end else begin
            a = 16'($urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 0) a[2:0] = 3'd0;
            free_req(a);
        end
    endtask

    task automatic test_directed();
        logic [15:0] a;
        alloc_req(0);
        alloc_req(1);
        alloc_req(4088);
        alloc_req(4089);
        alloc_req(65536);
        free_req(16'd0);
        free_req(16'd4);
        free_req(16'd12);
        free_req(16'hffff);
        free_req(16'd65528);
        wait_idle();
        a = live_blocks.pop_front();
        free_req(a);
        free_req(a);
        alloc_req(0);
        alloc_req(56);
        alloc_req(57);
        wait_idle();
    endtask

    task automatic test_random_phase(input longint first_len, input longint len, input int n);
        write_reg(CFG_INIT_PAGE, first_len);
        write_reg(CFG_PAGE, len);
        repeat (n) random_request(len);
        wait_idle();
    endtask

    // long output hold-off while requests keep coming
    task automatic test_backpressure();
        hold_req <= ~hold_req;
        repeat (40) random_request(600);
        wait_idle();
    endtask

    // output stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin : stall_gen
        static int hold_left = 0;
        static bit hold_seen = 1'b0;
        static int mode = 0;
        static int mode_left = 0;
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = 400;
        end
        if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        t_out_item e;
        if (o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: addr %0d class %0d status %0d",
                             o_out.granted_address, o_out.size_class, o_out.status);
            end else begin
                e = expected_q.pop_front();
                case (e.status)
                    ST_ALLOC: n_granted++;
                    ST_OOM:   n_oom++;
                    ST_FREED: n_freed++;
                    default:  n_ignored++;
                endcase
                if (o_out.granted_address !== e.granted_address ||
                    o_out.size_class !== e.size_class || o_out.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr %0d class %0d status %0d, got %0d %0d %0d",
                                 e.granted_address, e.size_class, e.status,
                                 o_out.granted_address, o_out.size_class, o_out.status);
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_phase(4096, 4096, 120);
        test_random_phase(64, 64, 100);
        test_backpressure();
        test_random_phase(65536, 65536, 40);
        test_random_phase(1000, 256, 100);
        test_random_phase(64, 65536, 40);
        wait_idle();
        if (expected_q.size() != 0) mismatches++;
        $display("covered: %0d grants, %0d out of memory, %0d frees, %0d ignored frees",
                 n_granted, n_oom, n_freed, n_ignored);
        $display("page settings from 64 to 65536 bytes, with gaps, stalls and a long hold-off");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
